/* rtl/pfrp_pkg.sv */
package pfrp_pkg;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_PUT   = 3'd0;
  localparam logic [2:0] MODE_GET   = 3'd1;
  localparam logic [2:0] MODE_PIN   = 3'd2;
  localparam logic [2:0] MODE_UNPIN = 3'd3;
  localparam logic [2:0] MODE_DIRTY = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_RESIDENT = 3'd1;
  localparam logic [2:0] ST_REFUSED  = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_UPDATED  = 3'd5;
  localparam logic [2:0] ST_ABSENT   = 3'd6;

  // Policy codes.
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_LFU  = 2'd2;

  // Configuration register indexes.
  localparam logic [0:0] REG_POLICY   = 1'b0;
  localparam logic [0:0] REG_CAPACITY = 1'b1;

  localparam int PIN_BITS = 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVICT,
    S_APPLY,
    S_OUT
  } state_t;

  // Command broadcast from the sequencer to every cell.
  typedef enum logic [2:0] {
    C_NONE,
    C_EVICT,
    C_INSERT,
    C_TOUCH,
    C_PIN,
    C_UNPIN,
    C_DIRTY
  } cmd_t;

endpackage

/* rtl/pfrp_cell.sv */
// One frame of the pool. During a scan the cell compares its contents with the
// candidate that arrives from its left neighbor and passes the better one on.
module pfrp_cell #(
  parameter int IDX_BITS  = 4,
  parameter int PAGE_BITS = 16,
  parameter int USE_BITS  = 16,
  parameter int RANK_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_BITS-1:0]  my_idx,
  // Scan candidate chain.
  input  logic                 c_in_found,
  input  logic [IDX_BITS-1:0]  c_in_idx,
  input  logic                 c_in_vic,
  input  logic [IDX_BITS-1:0]  c_in_vidx,
  input  logic [USE_BITS-1:0]  c_in_vuses,
  input  logic [RANK_BITS-1:0] c_in_vrank,
  input  logic                 c_in_vdirty,
  input  logic [PAGE_BITS-1:0] c_in_vpage,
  input  logic                 c_in_free,
  input  logic [IDX_BITS-1:0]  c_in_fidx,
  output logic                 c_out_found,
  output logic [IDX_BITS-1:0]  c_out_idx,
  output logic                 c_out_vic,
  output logic [IDX_BITS-1:0]  c_out_vidx,
  output logic [USE_BITS-1:0]  c_out_vuses,
  output logic [RANK_BITS-1:0] c_out_vrank,
  output logic                 c_out_vdirty,
  output logic [PAGE_BITS-1:0] c_out_vpage,
  output logic                 c_out_free,
  output logic [IDX_BITS-1:0]  c_out_fidx,
  // Broadcast controls.
  input  logic                 scan_en,
  input  logic                 lfu,
  input  logic [PAGE_BITS-1:0] key,
  input  pfrp_pkg::cmd_t       cmd,
  input  logic [IDX_BITS-1:0]  tgt,
  input  logic [RANK_BITS-1:0] ref_rank,
  input  logic [RANK_BITS-1:0] new_rank,
  input  logic                 cnt_use,
  output logic [RANK_BITS-1:0] rank_o
);

  logic                 valid_r, valid_nxt;
  logic                 dirty_r, dirty_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [RANK_BITS-1:0] rank_r, rank_nxt;
  logic [USE_BITS-1:0]  uses_r, uses_nxt;
  logic [pfrp_pkg::PIN_BITS-1:0] pins_r, pins_nxt;
  logic                 c_found_r, c_vic_r, c_vdirty_r, c_free_r;
  logic [IDX_BITS-1:0]  c_idx_r, c_vidx_r, c_fidx_r;
  logic [USE_BITS-1:0]  c_vuses_r;
  logic [RANK_BITS-1:0] c_vrank_r;
  logic [PAGE_BITS-1:0] c_vpage_r;
  logic                 me, cand, better;

  assign me   = (tgt == my_idx);
  assign cand = valid_r && (pins_r == '0);

  // Victim ordering: fewer uses under LFU, then older rank.
  always_comb begin
    if (!c_in_vic) begin
      better = 1'b1;
    end else if (lfu && (uses_r != c_in_vuses)) begin
      better = (uses_r < c_in_vuses);
    end else begin
      better = (rank_r < c_in_vrank);
    end
  end

  // Scan stage register, handed to the right neighbor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_found_r <= 1'b0;
      c_vic_r   <= 1'b0;
      c_free_r  <= 1'b0;
    end else if (scan_en) begin
      c_found_r <= c_in_found || (valid_r && (page_r == key));
      c_vic_r   <= c_in_vic || cand;
      c_free_r  <= c_in_free || !valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en) begin
      c_idx_r <= c_in_found ? c_in_idx : my_idx;
      c_fidx_r <= c_in_free ? c_in_fidx : my_idx;
      if (cand && better) begin
        c_vidx_r   <= my_idx;
        c_vuses_r  <= uses_r;
        c_vrank_r  <= rank_r;
        c_vdirty_r <= dirty_r;
        c_vpage_r  <= page_r;
      end else begin
        c_vidx_r   <= c_in_vidx;
        c_vuses_r  <= c_in_vuses;
        c_vrank_r  <= c_in_vrank;
        c_vdirty_r <= c_in_vdirty;
        c_vpage_r  <= c_in_vpage;
      end
    end
  end

  assign c_out_found  = c_found_r;
  assign c_out_idx    = c_idx_r;
  assign c_out_vic    = c_vic_r;
  assign c_out_vidx   = c_vidx_r;
  assign c_out_vuses  = c_vuses_r;
  assign c_out_vrank  = c_vrank_r;
  assign c_out_vdirty = c_vdirty_r;
  assign c_out_vpage  = c_vpage_r;
  assign c_out_free   = c_free_r;
  assign c_out_fidx   = c_fidx_r;

  // Frame update for the broadcast command.
  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    page_nxt  = page_r;
    rank_nxt  = rank_r;
    uses_nxt  = uses_r;
    pins_nxt  = pins_r;
    case (cmd)
      pfrp_pkg::C_EVICT: begin
        if (me) begin
          valid_nxt = 1'b0;
          dirty_nxt = 1'b0;
        end else if (valid_r && (rank_r > ref_rank)) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      pfrp_pkg::C_INSERT: begin
        if (me) begin
          valid_nxt = 1'b1;
          page_nxt  = key;
          rank_nxt  = new_rank;
          uses_nxt  = '0;
          pins_nxt  = '0;
          dirty_nxt = 1'b0;
        end
      end
      pfrp_pkg::C_TOUCH: begin
        if (me) begin
          rank_nxt = new_rank;
          if (cnt_use && (uses_r != '1)) begin
            uses_nxt = uses_r + 1'b1;
          end
        end else if (valid_r && (rank_r > ref_rank)) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      pfrp_pkg::C_PIN: begin
        if (me && (pins_r != '1)) begin
          pins_nxt = pins_r + 1'b1;
        end
      end
      pfrp_pkg::C_UNPIN: begin
        if (me && (pins_r != '0)) begin
          pins_nxt = pins_r - 1'b1;
        end
      end
      pfrp_pkg::C_DIRTY: begin
        if (me) begin
          dirty_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rank_r  <= '0;
      uses_r  <= '0;
      pins_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      rank_r  <= rank_nxt;
      uses_r  <= uses_nxt;
      pins_r  <= pins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign rank_o = rank_r;

endmodule

/* rtl/page_frame_replacement_policy.sv */
// Page frame replacement manager (FIFO, LRU, LFU with pinning). Frames sit in a
// row of cells; each operation launches a scan that ripples through the row,
// one cell per cycle, collecting the page match, the first free frame and the
// best victim. The result word is offered after the scan, evict and apply
// states; the next word is taken only once the result word has left the output
// register and the block has returned to idle. No clearing pass is needed.
module page_frame_replacement_policy #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int USE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: mode[2:0], page_number[PAGE_BITS+2:3], zero fill
  input  logic [((PAGE_BITS+3+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[2:0], frame_slot[6:3], evicted_valid[7],
  // evicted_page[PAGE_BITS+7:8], write_back[PAGE_BITS+8], zero fill
  output logic [((PAGE_BITS+9+7)/8)*8-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int CNT_BITS  = $clog2(FRAMES + 1);
  localparam int OUT_W     = ((PAGE_BITS + 9 + 7) / 8) * 8;

  pfrp_pkg::state_t state_r, state_nxt;
  logic [1:0]           policy_r;
  logic [4:0]           capacity_r;
  logic [2:0]           mode_r;
  logic [PAGE_BITS-1:0] key_r;
  logic [CNT_BITS-1:0]  used_r;
  logic [CNT_BITS:0]    scan_r;
  logic                 found_r, vic_r, vdirty_r, free_r;
  logic                 evict_r;
  logic [IDX_BITS-1:0]  idx_r, vidx_r, fidx_r;
  logic [PAGE_BITS-1:0] vpage_r;
  logic [2:0]           st_r;
  logic [3:0]           slot_r;
  logic                 evv_r, wb_r;
  logic [PAGE_BITS-1:0] evp_r;
  logic [CNT_BITS-1:0]  cap_eff;
  logic                 full;
  pfrp_pkg::cmd_t       cmd;
  logic [IDX_BITS-1:0]  tgt;
  logic [RANK_BITS-1:0] ref_rank, new_rank;
  logic [RANK_BITS-1:0] rank_w [FRAMES];

  // Scan chain wiring, position 0 is the constant empty candidate.
  logic                 ch_found [FRAMES+1];
  logic [IDX_BITS-1:0]  ch_idx   [FRAMES+1];
  logic                 ch_vic   [FRAMES+1];
  logic [IDX_BITS-1:0]  ch_vidx  [FRAMES+1];
  logic [USE_BITS-1:0]  ch_vuses [FRAMES+1];
  logic [RANK_BITS-1:0] ch_vrank [FRAMES+1];
  logic                 ch_vdirty[FRAMES+1];
  logic [PAGE_BITS-1:0] ch_vpage [FRAMES+1];
  logic                 ch_free  [FRAMES+1];
  logic [IDX_BITS-1:0]  ch_fidx  [FRAMES+1];

  assign ch_found[0]  = 1'b0;
  assign ch_idx[0]    = '0;
  assign ch_vic[0]    = 1'b0;
  assign ch_vidx[0]   = '0;
  assign ch_vuses[0]  = '0;
  assign ch_vrank[0]  = '0;
  assign ch_vdirty[0] = 1'b0;
  assign ch_vpage[0]  = '0;
  assign ch_free[0]   = 1'b0;
  assign ch_fidx[0]   = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    pfrp_cell #(
      .IDX_BITS(IDX_BITS), .PAGE_BITS(PAGE_BITS),
      .USE_BITS(USE_BITS), .RANK_BITS(RANK_BITS)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IDX_BITS'(g)),
      .c_in_found(ch_found[g]), .c_in_idx(ch_idx[g]),
      .c_in_vic(ch_vic[g]), .c_in_vidx(ch_vidx[g]),
      .c_in_vuses(ch_vuses[g]), .c_in_vrank(ch_vrank[g]),
      .c_in_vdirty(ch_vdirty[g]), .c_in_vpage(ch_vpage[g]),
      .c_in_free(ch_free[g]), .c_in_fidx(ch_fidx[g]),
      .c_out_found(ch_found[g+1]), .c_out_idx(ch_idx[g+1]),
      .c_out_vic(ch_vic[g+1]), .c_out_vidx(ch_vidx[g+1]),
      .c_out_vuses(ch_vuses[g+1]), .c_out_vrank(ch_vrank[g+1]),
      .c_out_vdirty(ch_vdirty[g+1]), .c_out_vpage(ch_vpage[g+1]),
      .c_out_free(ch_free[g+1]), .c_out_fidx(ch_fidx[g+1]),
      .scan_en(state_r == pfrp_pkg::S_SCAN), .lfu(policy_r == pfrp_pkg::POL_LFU),
      .key(key_r), .cmd(cmd), .tgt(tgt), .ref_rank(ref_rank),
      .new_rank(new_rank), .cnt_use(policy_r == pfrp_pkg::POL_LFU),
      .rank_o(rank_w[g])
    );
  end

  // Effective capacity: zero acts as one, large values clip to FRAMES.
  always_comb begin
    if (capacity_r == 5'd0) begin
      cap_eff = CNT_BITS'(1);
    end else if (32'(capacity_r) > FRAMES) begin
      cap_eff = CNT_BITS'(FRAMES);
    end else begin
      cap_eff = CNT_BITS'(capacity_r);
    end
  end
  assign full = (used_r >= cap_eff);

  // Configuration writes.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= pfrp_pkg::POL_FIFO;
      capacity_r <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == pfrp_pkg::REG_POLICY) begin
        policy_r <= cfg_data[1:0];
      end else begin
        capacity_r <= cfg_data;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfrp_pkg::S_IDLE:  if (in_tvalid) state_nxt = pfrp_pkg::S_SCAN;
      pfrp_pkg::S_SCAN:  if (scan_r == (CNT_BITS+1)'(FRAMES)) state_nxt = pfrp_pkg::S_EVICT;
      pfrp_pkg::S_EVICT: state_nxt = pfrp_pkg::S_APPLY;
      pfrp_pkg::S_APPLY: state_nxt = pfrp_pkg::S_OUT;
      pfrp_pkg::S_OUT:   if (out_tready) state_nxt = pfrp_pkg::S_IDLE;
      default:           state_nxt = pfrp_pkg::S_IDLE;
    endcase
  end

  // Command to the cells.
  always_comb begin
    cmd      = pfrp_pkg::C_NONE;
    tgt      = idx_r;
    ref_rank = rank_w[idx_r];
    new_rank = RANK_BITS'(used_r - 1'b1);
    unique case (state_r)
      pfrp_pkg::S_EVICT: begin
        if (mode_r == pfrp_pkg::MODE_PUT && !found_r && full && vic_r) begin
          cmd      = pfrp_pkg::C_EVICT;
          tgt      = vidx_r;
          ref_rank = rank_w[vidx_r];
        end
      end
      pfrp_pkg::S_APPLY: begin
        if (mode_r == pfrp_pkg::MODE_PUT) begin
          // After an eviction the lowest free frame is the victim's or a lower-indexed free one.
          if (!found_r && (evict_r || !full)) begin
            cmd = pfrp_pkg::C_INSERT;
            if (evict_r && !(free_r && (fidx_r < vidx_r))) begin
              tgt = vidx_r;
            end else begin
              tgt = fidx_r;
            end
            new_rank = RANK_BITS'(used_r);
          end
        end else if (found_r) begin
          case (mode_r)
            pfrp_pkg::MODE_GET:   if (policy_r == pfrp_pkg::POL_LRU ||
                                      policy_r == pfrp_pkg::POL_LFU) cmd = pfrp_pkg::C_TOUCH;
            pfrp_pkg::MODE_PIN:   cmd = pfrp_pkg::C_PIN;
            pfrp_pkg::MODE_UNPIN: cmd = pfrp_pkg::C_UNPIN;
            pfrp_pkg::MODE_DIRTY: cmd = pfrp_pkg::C_DIRTY;
            default:              cmd = pfrp_pkg::C_NONE;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign in_tready  = (state_r == pfrp_pkg::S_IDLE);
  assign out_tvalid = (state_r == pfrp_pkg::S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfrp_pkg::S_IDLE;
      used_r  <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pfrp_pkg::S_SCAN) begin
        scan_r <= scan_r + 1'b1;
      end else begin
        scan_r <= '0;
      end
      if (cmd == pfrp_pkg::C_EVICT) begin
        used_r <= used_r - 1'b1;
      end else if (cmd == pfrp_pkg::C_INSERT) begin
        used_r <= used_r + 1'b1;
      end
    end
  end

  // Operation capture, scan results and the result word.
  always_ff @(posedge clk) begin
    if (state_r == pfrp_pkg::S_IDLE && in_tvalid) begin
      mode_r <= in_tdata[2:0];
      key_r  <= in_tdata[PAGE_BITS+2:3];
    end
    if (state_r == pfrp_pkg::S_SCAN && scan_r == (CNT_BITS+1)'(FRAMES)) begin
      found_r  <= ch_found[FRAMES];
      idx_r    <= ch_idx[FRAMES];
      vic_r    <= ch_vic[FRAMES];
      vidx_r   <= ch_vidx[FRAMES];
      vdirty_r <= ch_vdirty[FRAMES];
      vpage_r  <= ch_vpage[FRAMES];
      free_r   <= ch_free[FRAMES];
      fidx_r   <= ch_fidx[FRAMES];
    end
    if (state_r == pfrp_pkg::S_EVICT) begin
      evict_r <= (cmd == pfrp_pkg::C_EVICT);
    end
    if (state_r == pfrp_pkg::S_APPLY) begin
      st_r   <= pfrp_pkg::ST_ABSENT;
      slot_r <= '0;
      evv_r  <= 1'b0;
      evp_r  <= '0;
      wb_r   <= 1'b0;
      if (mode_r == pfrp_pkg::MODE_PUT) begin
        if (found_r) begin
          st_r   <= pfrp_pkg::ST_RESIDENT;
          slot_r <= 4'(idx_r);
        end else if (cmd == pfrp_pkg::C_INSERT) begin
          st_r   <= pfrp_pkg::ST_INSERTED;
          slot_r <= 4'(tgt);
          if (evict_r) begin
            evv_r <= 1'b1;
            evp_r <= vpage_r;
            wb_r  <= vdirty_r;
          end
        end else begin
          st_r <= pfrp_pkg::ST_REFUSED;
        end
      end else if (mode_r == pfrp_pkg::MODE_GET) begin
        st_r   <= found_r ? pfrp_pkg::ST_HIT : pfrp_pkg::ST_MISS;
        slot_r <= found_r ? 4'(idx_r) : 4'd0;
      end else if (mode_r == pfrp_pkg::MODE_PIN || mode_r == pfrp_pkg::MODE_UNPIN ||
                   mode_r == pfrp_pkg::MODE_DIRTY) begin
        if (found_r) begin
          st_r   <= pfrp_pkg::ST_UPDATED;
          slot_r <= 4'(idx_r);
        end
      end
    end
  end

  assign out_tdata = OUT_W'({wb_r, evp_r, evv_r, slot_r, st_r});

endmodule

/* rtl/pfrp_checker.sv */
module pfrp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [2:0] out_status,
  input logic       out_evv,
  input logic       out_wb
);

  // No new word is taken while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  // A write-back only accompanies an eviction.
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_wb |-> out_evv) else $error("write-back without eviction");

  // Evictions come only with an insert.
  a_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_evv |-> out_status == pfrp_pkg::ST_INSERTED)
    else $error("stray eviction");

  // A result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

endmodule

bind page_frame_replacement_policy pfrp_checker u_pfrp_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_status(out_tdata[2:0]),
  .out_evv(out_tdata[7]), .out_wb(out_tdata[PAGE_BITS+8])
);
